// ----- src/pmdf_pkg.sv -----
// pmdf_pkg: shared types, constants and saturation helpers for the pen mass drag filter
// no dependencies; compile first
package pmdf_pkg;

    localparam int POS_W   = 18;
    localparam int OUT_W   = 22;
    localparam int POS_MAX = 131071;
    localparam int POS_MIN = -131072;
    localparam int OUT_MAX = 2097151;
    localparam int OUT_MIN = -2097152;
    localparam int DIR_ONE = 65536;

    // operation of the shared root / divide unit
    typedef enum logic {
        RD_SQRT = 1'b0,
        RD_DIV  = 1'b1
    } t_rd_op;

    typedef struct packed {
        logic   start;
        t_rd_op op;
    } t_rd_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rd_rsp;

    // saturate a wide signed value to the 18 bit state range
    function automatic logic signed [POS_W-1:0] f_sat18(input logic signed [37:0] v);
        if (v > 38'(POS_MAX)) begin
            return POS_W'(POS_MAX);
        end else if (v < 38'(POS_MIN)) begin
            return POS_W'(POS_MIN);
        end
        return v[POS_W-1:0];
    endfunction

    // saturate a wide signed value to the 22 bit output range
    function automatic logic signed [OUT_W-1:0] f_sat22(input logic signed [37:0] v);
        if (v > 38'(OUT_MAX)) begin
            return OUT_W'(OUT_MAX);
        end else if (v < 38'(OUT_MIN)) begin
            return OUT_W'(OUT_MIN);
        end
        return v[OUT_W-1:0];
    endfunction

    // clamp a direction component to +-1.0
    function automatic logic signed [17:0] f_clamp_dir(input logic signed [17:0] a);
        if (a > 18'(DIR_ONE)) begin
            return 18'(DIR_ONE);
        end else if (a < 18'(-DIR_ONE)) begin
            return 18'(-DIR_ONE);
        end
        return a;
    endfunction

    // apply sign to an unsigned quotient, clamped to +-1.0
    function automatic logic signed [17:0] f_dir_scale(input logic [17:0] q, input logic neg);
        logic [17:0] qc;
        qc = (q > 18'(DIR_ONE)) ? 18'(DIR_ONE) : q;
        return neg ? 18'(18'd0 - qc) : qc;
    endfunction

endpackage

// ----- src/pmdf_in_if.sv -----
// pmdf_in_if: input sample channel (valid / ready with func and pen position)
// no dependencies
interface pmdf_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [17:0] pen_x;
    logic signed [17:0] pen_y;

    modport source (output valid, func, pen_x, pen_y, input ready);
    modport sink (input valid, func, pen_x, pen_y, output ready);
endinterface

// ----- src/pmdf_out_if.sv -----
// pmdf_out_if: result channel (valid / ready with scaled position and nib direction)
// no dependencies
interface pmdf_out_if;
    logic               valid;
    logic               ready;
    logic signed [21:0] out_x;
    logic signed [21:0] out_y;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;

    modport source (output valid, out_x, out_y, dir_x, dir_y, input ready);
    modport sink (input valid, out_x, out_y, dir_x, dir_y, output ready);
endinterface

// ----- src/pmdf_mul.sv -----
// pmdf_mul: shared 19 x 18 signed multiplier with registered product
// no package dependencies
module pmdf_mul (
    input  logic               i_clk,
    input  logic signed [18:0] i_a,
    input  logic signed [17:0] i_b,
    output logic signed [36:0] o_p
);

    logic signed [36:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 37'(i_a) * 37'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- src/pmdf_root_div.sv -----
// pmdf_root_div: iterative square root and restoring divider on one shared subtractor
// depends on pmdf_pkg
module pmdf_root_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pmdf_pkg::t_rd_req i_req,
    input  logic [35:0]       i_rad,
    input  logic [46:0]       i_num,
    input  logic [29:0]       i_div,
    output pmdf_pkg::t_rd_rsp o_rsp,
    output logic [29:0]       o_result
);

    localparam int SQRT_STEPS = 30;
    localparam int DIV_STEPS  = 18;
    localparam int CNT_W      = 5;

    pmdf_pkg::t_rd_op r_op;
    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [30:0]      r_rem;
    logic [59:0]      r_rad;
    logic [29:0]      r_root;

    logic [32:0]      w_cur;
    logic [32:0]      w_sub;
    logic [33:0]      w_diff;
    logic             w_ge;
    logic [30:0]      w_rem_next;

    // one root bit from a radicand bit pair, or one quotient bit, per step
    always_comb begin
        if (r_op == pmdf_pkg::RD_SQRT) begin
            w_cur = {r_rem, r_rad[59:58]};
            w_sub = {1'b0, r_root, 2'b01};
        end else begin
            w_cur = {2'b00, r_rem[29:0], r_rad[59]};
            w_sub = {3'b000, i_div};
        end
        w_diff     = {1'b0, w_cur} - {1'b0, w_sub};
        w_ge       = ~w_diff[33];
        w_rem_next = w_ge ? w_diff[30:0] : w_cur[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= (i_req.op == pmdf_pkg::RD_SQRT) ? CNT_W'(SQRT_STEPS - 1)
                                                      : CNT_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= (r_cnt != '0);
            r_done <= (r_cnt == '0);
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op   <= i_req.op;
            r_root <= '0;
            if (i_req.op == pmdf_pkg::RD_SQRT) begin
                r_rad <= {i_rad, 24'd0};
                r_rem <= '0;
            end else begin
                r_rad <= {i_num[17:0], 42'd0};
                r_rem <= {2'b00, i_num[46:18]};
            end
        end else if (r_busy) begin
            r_rem  <= w_rem_next;
            r_root <= {r_root[28:0], w_ge};
            r_rad  <= (r_op == pmdf_pkg::RD_SQRT) ? {r_rad[57:0], 2'b00}
                                                  : {r_rad[58:0], 1'b0};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_result   = r_root;

endmodule

// ----- src/pen_mass_drag_filter.sv -----
// pen_mass_drag_filter: top level, sequencer and state of the damped pen mass filter
// depends on pmdf_pkg, pmdf_in_if, pmdf_out_if, pmdf_mul, pmdf_root_div
//
// usage
//   i_in carries pen samples: func 0 begins a stroke at the sample, func 1 is a move.
//   o_out carries one result per move that has nonzero force and nonzero velocity:
//   the filtered position times the surface size (Q.4) and the nib direction (Q1.16).
//   configuration is written on i_cfg_we / i_cfg_idx / i_cfg_data, one register a
//   cycle; the user must write it only while the block is idle; the block does not check.
//   i_in.ready is high only while the sequencer is idle; one item is worked at a time.
//   begin items and zero force moves finish in the idle step; zero velocity moves end
//   after the force steps. a fixed angle move runs the force, drag and scale steps,
//   then the output step. a move that follows velocity also waits on the shared
//   root / divide unit, which runs a 30 step square root and two 18 step
//   divisions, one step per cycle.
//   all products go through one registered 19 x 18 multiplier, one per cycle.
//   the result sits in an output register; a new sample is taken while it waits, and
//   the sequencer holds its next result until the receiver has taken the old one.
//   synchronous reset clears position, velocity, handshakes and loads register defaults.
module pen_mass_drag_filter #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pmdf_in_if.sink           i_in,
    pmdf_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [17:0]       i_cfg_data
);

    localparam int OUT_SHIFT = FRAC_BITS - 4;

    // register reset values
    localparam logic [16:0]        RST_INV_MASS = 17'd25304;
    localparam logic [16:0]        RST_DAMPING  = 17'd34066;
    localparam logic signed [17:0] RST_COS      = 18'sd61584;
    localparam logic signed [17:0] RST_SIN      = 18'sd22415;
    localparam logic [15:0]        RST_SURFACE  = 16'd1024;

    typedef enum logic [2:0] {
        CFG_INV_MASS = 3'd0,
        CFG_DAMPING  = 3'd1,
        CFG_FIXED_ON = 3'd2,
        CFG_COS      = 3'd3,
        CFG_SIN      = 3'd4,
        CFG_WIDTH    = 3'd5,
        CFG_HEIGHT   = 3'd6
    } t_cfg_idx;

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_ACC_X = 20'h00002,
        S_ACC_Y = 20'h00004,
        S_ACC_W = 20'h00008,
        S_SQ_X  = 20'h00010,
        S_SQ_Y  = 20'h00020,
        S_SQ_W  = 20'h00040,
        S_RT_GO = 20'h00080,
        S_RT_WT = 20'h00100,
        S_DX_GO = 20'h00200,
        S_DX_WT = 20'h00400,
        S_DY_GO = 20'h00800,
        S_DY_WT = 20'h01000,
        S_DMP_X = 20'h02000,
        S_DMP_Y = 20'h04000,
        S_DMP_W = 20'h08000,
        S_SCL_X = 20'h10000,
        S_SCL_Y = 20'h20000,
        S_SCL_W = 20'h40000,
        S_OUT   = 20'h80000
    } t_state;

    t_state             r_state;
    t_state             n_state;

    // configuration
    logic [16:0]        r_inv_mass;
    logic [16:0]        r_damping;
    logic               r_fixed;
    logic signed [17:0] r_cos;
    logic signed [17:0] r_sin;
    logic [15:0]        r_sw;
    logic [15:0]        r_sh;

    // filter state
    logic signed [17:0] r_pos_x;
    logic signed [17:0] r_pos_y;
    logic signed [17:0] r_vel_x;
    logic signed [17:0] r_vel_y;

    // working registers
    logic signed [18:0] r_fx;
    logic signed [18:0] r_fy;
    logic [35:0]        r_n;
    logic [29:0]        r_m;
    logic [17:0]        r_mag;
    logic               r_neg;
    logic signed [17:0] r_dx;
    logic signed [17:0] r_dy;
    logic signed [21:0] r_ox;
    logic signed [21:0] r_oy;

    // output register
    logic               r_out_valid;
    logic signed [21:0] r_out_x;
    logic signed [21:0] r_out_y;
    logic signed [17:0] r_out_dx;
    logic signed [17:0] r_out_dy;

    logic               w_in_xfer;
    logic               w_out_free;
    logic signed [18:0] w_fx;
    logic signed [18:0] w_fy;
    logic               w_force_zero;

    logic signed [18:0] w_mul_a;
    logic signed [17:0] w_mul_b;
    logic signed [36:0] w_prod;
    logic signed [37:0] w_prod_ext;
    logic signed [37:0] w_rnd16;
    logic signed [37:0] w_rnd_out;

    logic signed [17:0] w_vel_sel;
    logic signed [17:0] w_vel_acc;
    logic signed [17:0] w_vel_dmp;
    logic signed [17:0] w_pos_sel;
    logic signed [17:0] w_pos_new;
    logic signed [17:0] w_mag_src;
    logic [18:0]        w_neg19;
    logic [17:0]        w_mag;

    pmdf_pkg::t_rd_req  w_req;
    pmdf_pkg::t_rd_rsp  w_rsp;
    logic [46:0]        w_num;
    logic [29:0]        w_result;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // force is the sample minus the position, one bit wider than the state
    assign w_fx = {i_in.pen_x[17], i_in.pen_x} - {r_pos_x[17], r_pos_x};
    assign w_fy = {i_in.pen_y[17], i_in.pen_y} - {r_pos_y[17], r_pos_y};
    assign w_force_zero = (w_fx == '0) && (w_fy == '0);

    // rounding of the last product: fixed Q16 for mass and drag, FRAC_BITS-4 for output
    assign w_prod_ext = 38'(w_prod);
    assign w_rnd16    = (w_prod_ext + 38'sd32768) >>> 16;
    assign w_rnd_out  = (w_prod_ext + (38'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;

    // velocity after the force step, x in the first take cycle and y in the second
    assign w_vel_sel = (r_state == S_ACC_Y) ? r_vel_x : r_vel_y;
    assign w_vel_acc = pmdf_pkg::f_sat18(38'(w_vel_sel) + w_rnd16);

    // damped velocity and advanced position
    assign w_vel_dmp = pmdf_pkg::f_sat18(w_rnd16);
    assign w_pos_sel = (r_state == S_DMP_Y) ? r_pos_x : r_pos_y;
    assign w_pos_new = pmdf_pkg::f_sat18(38'(w_pos_sel) + 38'(w_vel_dmp));

    // magnitude for the divide: |vy| for dir_x, |vx| for dir_y
    assign w_mag_src = (r_state == S_RT_WT) ? r_vel_y : r_vel_x;
    assign w_neg19   = 19'd0 - {w_mag_src[17], w_mag_src};
    assign w_mag     = w_mag_src[17] ? w_neg19[17:0] : w_mag_src;

    // rounded dividend: mag * 2^28 + m / 2
    assign w_num = {1'b0, r_mag, 28'd0} + {18'd0, r_m[29:1]};

    // multiplier operands and unit requests by step
    always_comb begin
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_req.start = 1'b0;
        w_req.op    = pmdf_pkg::RD_SQRT;
        case (r_state)
            S_ACC_X: begin
                w_mul_a = r_fx;
                w_mul_b = {1'b0, r_inv_mass};
            end
            S_ACC_Y: begin
                w_mul_a = r_fy;
                w_mul_b = {1'b0, r_inv_mass};
            end
            S_SQ_X: begin
                w_mul_a = {r_vel_x[17], r_vel_x};
                w_mul_b = r_vel_x;
            end
            S_SQ_Y: begin
                w_mul_a = {r_vel_y[17], r_vel_y};
                w_mul_b = r_vel_y;
            end
            S_RT_GO: begin
                w_req.start = 1'b1;
                w_req.op    = pmdf_pkg::RD_SQRT;
            end
            S_DX_GO, S_DY_GO: begin
                w_req.start = 1'b1;
                w_req.op    = pmdf_pkg::RD_DIV;
            end
            S_DMP_X: begin
                w_mul_a = {r_vel_x[17], r_vel_x};
                w_mul_b = {1'b0, r_damping};
            end
            S_DMP_Y: begin
                w_mul_a = {r_vel_y[17], r_vel_y};
                w_mul_b = {1'b0, r_damping};
            end
            S_SCL_X: begin
                w_mul_a = {r_pos_x[17], r_pos_x};
                w_mul_b = {2'b00, r_sw};
            end
            S_SCL_Y: begin
                w_mul_a = {r_pos_y[17], r_pos_y};
                w_mul_b = {2'b00, r_sh};
            end
            default: begin
            end
        endcase
    end

    pmdf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    pmdf_root_div u_root_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_rad    (r_n),
        .i_num    (w_num),
        .i_div    (r_m),
        .o_rsp    (w_rsp),
        .o_result (w_result)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer && i_in.func && !w_force_zero) begin
                    n_state = S_ACC_X;
                end
            end
            S_ACC_X: n_state = S_ACC_Y;
            S_ACC_Y: n_state = S_ACC_W;
            S_ACC_W: begin
                // no result when the new velocity is zero in both components
                if (r_vel_x == '0 && w_vel_acc == '0) begin
                    n_state = S_IDLE;
                end else if (r_fixed) begin
                    n_state = S_DMP_X;
                end else begin
                    n_state = S_SQ_X;
                end
            end
            S_SQ_X:  n_state = S_SQ_Y;
            S_SQ_Y:  n_state = S_SQ_W;
            S_SQ_W:  n_state = S_RT_GO;
            S_RT_GO: n_state = S_RT_WT;
            S_RT_WT: begin
                if (w_rsp.done) begin
                    n_state = S_DX_GO;
                end
            end
            S_DX_GO: n_state = S_DX_WT;
            S_DX_WT: begin
                if (w_rsp.done) begin
                    n_state = S_DY_GO;
                end
            end
            S_DY_GO: n_state = S_DY_WT;
            S_DY_WT: begin
                if (w_rsp.done) begin
                    n_state = S_DMP_X;
                end
            end
            S_DMP_X: n_state = S_DMP_Y;
            S_DMP_Y: n_state = S_DMP_W;
            S_DMP_W: n_state = S_SCL_X;
            S_SCL_X: n_state = S_SCL_Y;
            S_SCL_Y: n_state = S_SCL_W;
            S_SCL_W: n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_mass <= RST_INV_MASS;
            r_damping  <= RST_DAMPING;
            r_fixed    <= 1'b0;
            r_cos      <= RST_COS;
            r_sin      <= RST_SIN;
            r_sw       <= RST_SURFACE;
            r_sh       <= RST_SURFACE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INV_MASS: r_inv_mass <= i_cfg_data[16:0];
                CFG_DAMPING:  r_damping  <= i_cfg_data[16:0];
                CFG_FIXED_ON: r_fixed    <= i_cfg_data[0];
                CFG_COS:      r_cos      <= i_cfg_data;
                CFG_SIN:      r_sin      <= i_cfg_data;
                CFG_WIDTH:    r_sw       <= i_cfg_data[15:0];
                CFG_HEIGHT:   r_sh       <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // position and velocity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_vel_x <= '0;
            r_vel_y <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    // begin stroke: jump to the sample at rest
                    if (w_in_xfer && !i_in.func) begin
                        r_pos_x <= i_in.pen_x;
                        r_pos_y <= i_in.pen_y;
                        r_vel_x <= '0;
                        r_vel_y <= '0;
                    end
                end
                S_ACC_Y: r_vel_x <= w_vel_acc;
                S_ACC_W: r_vel_y <= w_vel_acc;
                S_DMP_Y: begin
                    r_vel_x <= w_vel_dmp;
                    r_pos_x <= w_pos_new;
                end
                S_DMP_W: begin
                    r_vel_y <= w_vel_dmp;
                    r_pos_y <= w_pos_new;
                end
                default: begin
                end
            endcase
        end
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_fx <= w_fx;
                r_fy <= w_fy;
            end
            S_ACC_W: begin
                r_dx <= pmdf_pkg::f_clamp_dir(r_cos);
                r_dy <= pmdf_pkg::f_clamp_dir(r_sin);
            end
            S_SQ_Y: r_n <= w_prod[35:0];
            S_SQ_W: r_n <= r_n + w_prod[35:0];
            S_RT_WT: begin
                // dir_x comes from -vy
                r_m   <= w_result;
                r_mag <= w_mag;
                r_neg <= !r_vel_y[17] && (r_vel_y != '0);
            end
            S_DX_WT: begin
                if (w_rsp.done) begin
                    r_dx  <= pmdf_pkg::f_dir_scale(w_result[17:0], r_neg);
                    r_mag <= w_mag;
                    r_neg <= r_vel_x[17];
                end
            end
            S_DY_WT: begin
                if (w_rsp.done) begin
                    r_dy <= pmdf_pkg::f_dir_scale(w_result[17:0], r_neg);
                end
            end
            S_SCL_Y: r_ox <= pmdf_pkg::f_sat22(w_rnd_out);
            S_SCL_W: r_oy <= pmdf_pkg::f_sat22(w_rnd_out);
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out_x  <= r_ox;
            r_out_y  <= r_oy;
            r_out_dx <= r_dx;
            r_out_dy <= r_dy;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.out_x = r_out_x;
    assign o_out.out_y = r_out_y;
    assign o_out.dir_x = r_out_dx;
    assign o_out.dir_y = r_out_dy;

`ifndef SYNTH
    // the root / divide unit is never restarted while it iterates
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy)
        else $error("root/div start while busy");

    // a finished root or quotient is always awaited by the sequencer
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_RT_WT || r_state == S_DX_WT || r_state == S_DY_WT))
        else $error("root/div done outside a wait step");

    // a nonzero velocity gives a root of at least 2^12
    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DX_GO) |-> (r_m >= 30'd4096))
        else $error("divisor below range");

    // results appear only from the output step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result valid without output step");

    // delivered direction stays within unit range
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_dx <= 18'sd65536 && r_out_dx >= -18'sd65536
                      && r_out_dy <= 18'sd65536 && r_out_dy >= -18'sd65536))
        else $error("direction out of range");
`endif

endmodule

// ----- verif/pen_mass_drag_filter_tb.sv -----
// pen_mass_drag_filter_tb: self-checking bench for the damped pen mass filter
// depends on pmdf_pkg, pmdf_in_if, pmdf_out_if and the pen_mass_drag_filter rtl
// checks every result against an in-bench mass / drag predictor under random flow
`timescale 1ns / 1ps

module pen_mass_drag_filter_tb;

    localparam int FRAC_BITS      = 16;
    localparam int RESET_CYCLES   = 10;
    // a zero velocity move can still be busy after the last result
    localparam int SETTLE_CYCLES  = 200;
    // longest quiet stretch of a good run is the receiver hold plus one follow move
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRESSURE_AT    = 400;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_REPORTS    = 100;
    localparam int PHASE_ITEMS    = 215;

    // value limits shared with the rtl
    localparam int POS_MAX = pmdf_pkg::POS_MAX;
    localparam int POS_MIN = pmdf_pkg::POS_MIN;
    localparam int OUT_MAX = pmdf_pkg::OUT_MAX;
    localparam int OUT_MIN = pmdf_pkg::OUT_MIN;
    localparam int DIR_ONE = pmdf_pkg::DIR_ONE;

    // register map of the write port
    localparam logic [2:0] REG_INVERSE_MASS   = 3'd0;
    localparam logic [2:0] REG_DAMPING        = 3'd1;
    localparam logic [2:0] REG_FIXED_ANGLE_ON = 3'd2;
    localparam logic [2:0] REG_ANGLE_COS      = 3'd3;
    localparam logic [2:0] REG_ANGLE_SIN      = 3'd4;
    localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd5;
    localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd6;

    // sample functions
    localparam logic FUNC_BEGIN = 1'b0;
    localparam logic FUNC_MOVE  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [17:0] pen_x;
        logic [17:0] pen_y;
    } t_pen_sample;

    typedef struct packed {
        logic [21:0] out_x;
        logic [21:0] out_y;
        logic [17:0] dir_x;
        logic [17:0] dir_y;
    } t_filt_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [17:0] i_cfg_data;

    pmdf_in_if  in_if();
    pmdf_out_if out_if();

    pen_mass_drag_filter #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // stimulus waiting to be offered, and filtered points still owed by the block
    t_pen_sample samples_to_send[$];
    t_filt_point points_due[$];

    // predictor copy of the register file
    logic [16:0]        cfg_inverse_mass;
    logic [16:0]        cfg_damping;
    logic               cfg_fixed_angle;
    logic signed [17:0] cfg_angle_cos;
    logic signed [17:0] cfg_angle_sin;
    logic [15:0]        cfg_surface_w;
    logic [15:0]        cfg_surface_h;

    // predictor copy of the mass state
    longint mass_pos_x, mass_pos_y, mass_vel_x, mass_vel_y;

    int     send_idle_pct;
    int     recv_idle_pct;
    int     mismatch_count   = 0;
    int     accepted_samples = 0;
    int     quiet_cycles     = 0;
    int     hold_left        = 0;
    bit     hold_done        = 1'b0;
    bit     in_taken         = 1'b0;

    t_pen_sample drv_sample;
    t_pen_sample mon_sample;
    t_filt_point mon_point;
    t_filt_point mon_want;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // round half up, then drop s fraction bits
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // one direction component: |a| / m in Q1.16, sign restored, clamped to unit
    function automatic longint norm_axis(input longint a, input longint unsigned m);
        longint unsigned mag;
        longint          q;
        mag = $unsigned((a < 0) ? -a : a);
        q   = longint'(((mag << 28) + (m >> 1)) / m);
        return clip((a < 0) ? -q : q, -DIR_ONE, DIR_ONE);
    endfunction

    // advance the mass by one sample; returns 1 with the filtered point when
    // the sample produces output
    function automatic bit advance_pen_mass(input t_pen_sample s, output t_filt_point p);
        longint          px, py, fx, fy, dx, dy, ox, oy, inv, damp;
        longint unsigned root_in, root, bitv;
        p    = '0;
        px   = longint'($signed(s.pen_x));
        py   = longint'($signed(s.pen_y));
        inv  = longint'(cfg_inverse_mass);
        damp = longint'(cfg_damping);

        // start of a stroke: jump to the sample at rest
        if (s.func == FUNC_BEGIN) begin
            mass_pos_x = px;
            mass_pos_y = py;
            mass_vel_x = 0;
            mass_vel_y = 0;
            return 1'b0;
        end

        // pen sitting on the mass: nothing moves
        fx = px - mass_pos_x;
        fy = py - mass_pos_y;
        if (fx == 0 && fy == 0) begin
            return 1'b0;
        end

        mass_vel_x = clip(mass_vel_x + round_shift(fx * inv, 16), POS_MIN, POS_MAX);
        mass_vel_y = clip(mass_vel_y + round_shift(fy * inv, 16), POS_MIN, POS_MAX);
        // velocity rounded away to nothing: no output, velocity kept
        if (mass_vel_x == 0 && mass_vel_y == 0) begin
            return 1'b0;
        end

        if (cfg_fixed_angle) begin
            dx = clip(longint'(cfg_angle_cos), -DIR_ONE, DIR_ONE);
            dy = clip(longint'(cfg_angle_sin), -DIR_ONE, DIR_ONE);
        end else begin
            // |v| scaled by 2^12 through an integer square root of |v|^2 * 2^24
            root_in = $unsigned(mass_vel_x * mass_vel_x + mass_vel_y * mass_vel_y) << 24;
            root    = 0;
            bitv    = 64'd1 << 62;
            while (bitv > root_in) begin
                bitv = bitv >> 2;
            end
            while (bitv != 0) begin
                if (root_in >= root + bitv) begin
                    root_in = root_in - (root + bitv);
                    root    = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            // nib lies across the motion: velocity turned a quarter turn
            dx = norm_axis(-mass_vel_y, root);
            dy = norm_axis(mass_vel_x, root);
        end

        mass_vel_x = clip(round_shift(mass_vel_x * damp, 16), POS_MIN, POS_MAX);
        mass_vel_y = clip(round_shift(mass_vel_y * damp, 16), POS_MIN, POS_MAX);
        mass_pos_x = clip(mass_pos_x + mass_vel_x, POS_MIN, POS_MAX);
        mass_pos_y = clip(mass_pos_y + mass_vel_y, POS_MIN, POS_MAX);

        ox = clip(round_shift(mass_pos_x * longint'(cfg_surface_w), FRAC_BITS - 4),
                  OUT_MIN, OUT_MAX);
        oy = clip(round_shift(mass_pos_y * longint'(cfg_surface_h), FRAC_BITS - 4),
                  OUT_MIN, OUT_MAX);

        p.out_x = 22'(ox);
        p.out_y = 22'(oy);
        p.dir_x = 18'(dx);
        p.dir_y = 18'(dy);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        // keep the log bounded when everything goes wrong
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // one register write per falling edge, mirrored into the predictor
    task automatic write_reg(input logic [2:0] idx, input logic [17:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_INVERSE_MASS:   cfg_inverse_mass = data[16:0];
            REG_DAMPING:        cfg_damping      = data[16:0];
            REG_FIXED_ANGLE_ON: cfg_fixed_angle  = data[0];
            REG_ANGLE_COS:      cfg_angle_cos    = data;
            REG_ANGLE_SIN:      cfg_angle_sin    = data;
            REG_SURFACE_WIDTH:  cfg_surface_w    = data[15:0];
            REG_SURFACE_HEIGHT: cfg_surface_h    = data[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int inv, input int damp, input int fixed_on,
                              input int ang_c, input int ang_s, input int w, input int h);
        write_reg(REG_INVERSE_MASS, 18'(inv));
        write_reg(REG_DAMPING, 18'(damp));
        write_reg(REG_FIXED_ANGLE_ON, 18'(fixed_on));
        write_reg(REG_ANGLE_COS, 18'(ang_c));
        write_reg(REG_ANGLE_SIN, 18'(ang_s));
        write_reg(REG_SURFACE_WIDTH, 18'(w));
        write_reg(REG_SURFACE_HEIGHT, 18'(h));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // block is idle once everything is sent, every point is back and it has settled
    task automatic wait_block_idle();
        while (samples_to_send.size() != 0 || in_if.valid || points_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_sample(input logic f, input longint x, input longint y);
        t_pen_sample s;
        s.func  = f;
        s.pen_x = 18'(x);
        s.pen_y = 18'(y);
        samples_to_send.push_back(s);
    endtask

    function automatic longint rand_coord();
        return longint'($signed(18'($urandom)));
    endfunction

    // mostly strokes: a begin, sometimes a zero force move, then a pen path
    // drifting by small, medium or large steps; the rest is lone noise items
    task automatic add_strokes(input int n_items);
        int     made, moves, step;
        longint x, y;
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(99) < 10) begin
                queue_sample($urandom_range(1) ? FUNC_MOVE : FUNC_BEGIN,
                             rand_coord(), rand_coord());
                made++;
            end else begin
                if ($urandom_range(1)) begin
                    x = rand_coord();
                    y = rand_coord();
                end else begin
                    x = longint'(int'($urandom_range(65535)) - 32768);
                    y = longint'(int'($urandom_range(65535)) - 32768);
                end
                queue_sample(FUNC_BEGIN, x, y);
                made++;
                if ($urandom_range(99) < 15) begin
                    queue_sample(FUNC_MOVE, x, y);
                    made++;
                end
                moves = $urandom_range(16, 1);
                case ($urandom_range(2))
                    0:       step = 16;
                    1:       step = 512;
                    default: step = 8192;
                endcase
                repeat (moves) begin
                    if ($urandom_range(99) < 5) begin
                        x = rand_coord();
                        y = rand_coord();
                    end else begin
                        x = clip(x + int'($urandom_range(2 * step)) - step, POS_MIN, POS_MAX);
                        y = clip(y + int'($urandom_range(2 * step)) - step, POS_MIN, POS_MAX);
                    end
                    queue_sample(FUNC_MOVE, x, y);
                    made++;
                end
            end
        end
    endtask

    // sample driver: holds an offer until its transfer, new offers at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drv_sample = samples_to_send.pop_front();
                in_if.valid <= 1'b1;
                in_if.func  <= drv_sample.func;
                in_if.pen_x <= drv_sample.pen_x;
                in_if.pen_y <= drv_sample.pen_y;
            end else begin
                // idle: payload is junk the block must not look at
                in_if.valid <= 1'b0;
                in_if.func  <= 1'($urandom);
                in_if.pen_x <= 18'($urandom);
                in_if.pen_y <= 18'($urandom);
            end
        end
    end

    // point receiver: random stalls plus one long hold so the block backs up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (!hold_done && accepted_samples >= PRESSURE_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: check the outgoing transfer first, then predict from the incoming one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (points_due.size() == 0) begin
                    report_mismatch("point with nothing owed, out_x",
                                    longint'(out_if.out_x), 0);
                end else begin
                    mon_want = points_due.pop_front();
                    if (out_if.out_x !== mon_want.out_x) begin
                        report_mismatch("out_x", longint'(out_if.out_x),
                                        longint'($signed(mon_want.out_x)));
                    end
                    if (out_if.out_y !== mon_want.out_y) begin
                        report_mismatch("out_y", longint'(out_if.out_y),
                                        longint'($signed(mon_want.out_y)));
                    end
                    if (out_if.dir_x !== mon_want.dir_x) begin
                        report_mismatch("dir_x", longint'(out_if.dir_x),
                                        longint'($signed(mon_want.dir_x)));
                    end
                    if (out_if.dir_y !== mon_want.dir_y) begin
                        report_mismatch("dir_y", longint'(out_if.dir_y),
                                        longint'($signed(mon_want.dir_y)));
                    end
                end
            end
            in_taken = in_if.valid && in_if.ready;
            if (in_taken) begin
                accepted_samples++;
                mon_sample.func  = in_if.func;
                mon_sample.pen_x = in_if.pen_x;
                mon_sample.pen_y = in_if.pen_y;
                if (advance_pen_mass(mon_sample, mon_point)) begin
                    points_due.push_back(mon_point);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        in_if.valid  = 1'b0;
        in_if.func   = FUNC_BEGIN;
        in_if.pen_x  = '0;
        in_if.pen_y  = '0;
        out_if.ready = 1'b0;

        // register defaults and a mass at rest in the origin
        cfg_inverse_mass = 17'd25304;
        cfg_damping      = 17'd34066;
        cfg_fixed_angle  = 1'b0;
        cfg_angle_cos    = 18'sd61584;
        cfg_angle_sin    = 18'sd22415;
        cfg_surface_w    = 16'd1024;
        cfg_surface_h    = 16'd1024;
        mass_pos_x = 0;
        mass_pos_y = 0;
        mass_vel_x = 0;
        mass_vel_y = 0;

        // light sender gaps, heavy receiver stalls
        send_idle_pct = 7;
        recv_idle_pct = 59;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, on reset register values
        queue_sample(FUNC_MOVE, 0, 0);                // zero force from reset state
        queue_sample(FUNC_MOVE, 1, 0);                // force too small, velocity stays zero
        queue_sample(FUNC_MOVE, POS_MAX, POS_MAX);
        queue_sample(FUNC_MOVE, POS_MIN, POS_MIN);
        queue_sample(FUNC_MOVE, POS_MIN, POS_MAX);
        queue_sample(FUNC_MOVE, POS_MAX, POS_MIN);
        queue_sample(FUNC_BEGIN, POS_MAX, POS_MAX);
        queue_sample(FUNC_MOVE, POS_MAX, POS_MAX);    // zero force right after a begin
        queue_sample(FUNC_MOVE, POS_MIN, POS_MIN);    // full scale pull
        queue_sample(FUNC_BEGIN, POS_MIN, POS_MIN);
        queue_sample(FUNC_MOVE, POS_MIN, POS_MIN + 1);
        queue_sample(FUNC_MOVE, POS_MAX, POS_MAX);
        queue_sample(FUNC_BEGIN, 0, 0);
        queue_sample(FUNC_MOVE, 3, 0);
        queue_sample(FUNC_MOVE, 3, 0);
        queue_sample(FUNC_MOVE, 0, 3);
        queue_sample(FUNC_MOVE, -3, -3);
        queue_sample(FUNC_MOVE, 0, 0);
        queue_sample(FUNC_BEGIN, 65536, -65536);
        queue_sample(FUNC_MOVE, 69632, -65536);
        queue_sample(FUNC_MOVE, 65536, -61440);
        queue_sample(FUNC_MOVE, 0, 0);

        // lightest mass, no drag, extreme surface sizes
        wait_block_idle();
        set_config(65536, 65536, 0, 0, 0, 65535, 1);
        add_strokes(PHASE_ITEMS);

        // heaviest mass, most drag, fixed nib at the unit corners
        wait_block_idle();
        set_config(410, 32768, 1, -65536, 65536, 1, 65535);
        add_strokes(PHASE_ITEMS);

        // heavy sender gaps, light receiver stalls
        wait_block_idle();
        send_idle_pct = 59;
        recv_idle_pct = 7;
        set_config($urandom_range(65536, 410), $urandom_range(65536, 32768), 0,
                   int'($urandom_range(131072)) - 65536, int'($urandom_range(131072)) - 65536,
                   $urandom_range(65535, 1), $urandom_range(65535, 1));
        add_strokes(PHASE_ITEMS);

        // out of range values: angle clamping, velocity growth, zero surface
        wait_block_idle();
        set_config(131071, 131071, 1, -131072, 131071, 0, 0);
        add_strokes(PHASE_ITEMS);

        // full throughput from here on
        wait_block_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(25304, 34066, 1, int'($urandom_range(131072)) - 65536,
                   int'($urandom_range(131072)) - 65536, 1024, 1024);
        add_strokes(PHASE_ITEMS);

        // any value the register widths allow
        wait_block_idle();
        set_config($urandom_range(131071), $urandom_range(131071), 0,
                   int'($signed(18'($urandom))), int'($signed(18'($urandom))),
                   $urandom_range(65535), $urandom_range(65535));
        add_strokes(PHASE_ITEMS);

        wait_block_idle();
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
